// ===== hdl/mdfp_pkg.sv =====
// ============================================================================
// Motor drive fault protection package
// Command codes, register indexes, fixed constants and the input
// transaction type shared by the protection block.
// ============================================================================
package mdfp_pkg;

    // Command codes carried in the cmd field of an input transaction
    localparam logic [2:0] CMD_CURRENT = 3'd0;
    localparam logic [2:0] CMD_BUS     = 3'd1;
    localparam logic [2:0] CMD_TEMP    = 3'd2;
    localparam logic [2:0] CMD_GATE    = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_CURRENT_LIMIT = 2'd0;
    localparam logic [1:0] REG_BUS_NOMINAL   = 2'd1;
    localparam logic [1:0] REG_BUS_TOLERANCE = 2'd2;
    localparam logic [1:0] REG_TEMP_LIMIT    = 2'd3;

    // Configuration reset values
    localparam logic [14:0] CURRENT_LIMIT_RST = 15'd16000;
    localparam logic [13:0] BUS_NOMINAL_RST   = 14'd8640;
    localparam logic [13:0] BUS_TOLERANCE_RST = 14'd1600;
    localparam logic [10:0] TEMP_LIMIT_RST    = 11'd1000;

    // Fault flag bit positions
    localparam int FLT_OVERCURRENT = 0;
    localparam int FLT_MAX_CURRENT = 1;
    localparam int FLT_OVERVOLT    = 2;
    localparam int FLT_UNDERVOLT   = 3;
    localparam int FLT_OVERHEAT    = 4;

    // Brake chopper constants (630 V start, 80 V span in 1/16 V units)
    localparam logic [10:0] DUTY_FULL   = 11'd1024;
    localparam logic [10:0] DUTY_MIN    = 11'd102;
    localparam logic [13:0] BRAKE_START = 14'd10080;
    // Largest reduction that still leaves the duty at or above the minimum
    localparam logic [12:0] DUTY_CUT_MAX = 13'd922;
    // ceil(2^18 / 5): exact floor(x / 5) for every x below 2^15
    localparam logic [15:0] RECIP_FIFTH = 16'd52429;

    // Near-limit counter trips when it goes past this value
    localparam logic [3:0] NEAR_TRIP = 4'd10;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] phase_a;
        logic signed [15:0] phase_b;
        logic signed [15:0] phase_c;
        logic [13:0]        bus_voltage;
        logic signed [11:0] temperature;
        logic               enable_pin;
        logic               stop_value;
    } item_t;

endpackage

// ===== hdl/motor_drive_fault_protection.sv =====
// Path: a transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while results are taken; the input and result registers
// let a new transaction enter while the previous result waits to be taken.
// Reset (rst_n, asynchronous, active low): stop set, brake released, no faults, fan off,
// near-limit count zero, brake duty at full scale, configuration at its default values.
// No clearing pass is needed; the block is ready as soon as reset is released.
// ============================================================================
// Motor drive fault protection
// Checks phase currents, DC bus voltage and heatsink temperature of a
// three-phase inverter, latches sticky fault flags, drives the stop and
// brake outputs, the cooling fan and the brake chopper duty.
// ============================================================================
module motor_drive_fault_protection
(
    input  logic               clk,
    input  logic               rst_n,

    // Configuration write port
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,

    // Input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic signed [15:0] phase_a,
    input  logic signed [15:0] phase_b,
    input  logic signed [15:0] phase_c,
    input  logic [13:0]        bus_voltage,
    input  logic signed [11:0] temperature,
    input  logic               enable_pin,
    input  logic               stop_value,

    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               stop,
    output logic               brake_active,
    output logic [4:0]         fault_flags,
    output logic               fan_on,
    output logic [10:0]        brake_duty
);
    import mdfp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the block is idle;
    // the block itself does not enforce this, and the processing logic reads them directly.
    // ------------------------------------------------------------------
    logic [14:0] current_limit_reg;
    logic [13:0] bus_nominal_reg;
    logic [13:0] bus_tolerance_reg;
    logic [10:0] temp_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_limit_reg <= CURRENT_LIMIT_RST;
            bus_nominal_reg   <= BUS_NOMINAL_RST;
            bus_tolerance_reg <= BUS_TOLERANCE_RST;
            temp_limit_reg    <= TEMP_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CURRENT_LIMIT: current_limit_reg <= cfg_data;
                REG_BUS_NOMINAL:   bus_nominal_reg   <= cfg_data[13:0];
                REG_BUS_TOLERANCE: bus_tolerance_reg <= cfg_data[13:0];
                REG_TEMP_LIMIT:    temp_limit_reg    <= cfg_data[10:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register holds one transaction; it moves into
    // the result register, and updates the protection state, whenever the
    // result register is empty or its contents are being taken this cycle.
    // ------------------------------------------------------------------
    item_t item_reg;
    logic  item_valid_reg;
    logic  out_valid_reg;
    logic  out_free;
    logic  advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.cmd         <= cmd;
            item_reg.phase_a     <= phase_a;
            item_reg.phase_b     <= phase_b;
            item_reg.phase_c     <= phase_c;
            item_reg.bus_voltage <= bus_voltage;
            item_reg.temperature <= temperature;
            item_reg.enable_pin  <= enable_pin;
            item_reg.stop_value  <= stop_value;
        end
    end

    // ------------------------------------------------------------------
    // Protection state
    // ------------------------------------------------------------------
    logic        stop_reg,      stop_next;
    logic        brake_reg,     brake_next;
    logic [4:0]  fault_reg,     fault_next;
    logic [3:0]  near_cnt_reg,  near_cnt_next;
    logic        fan_reg,       fan_next;
    logic [10:0] duty_reg,      duty_next;

    // ------------------------------------------------------------------
    // Current checks. A sample is near the limit when 10|x| > 9L and over
    // it when |x| > L. Magnitudes need 17 bits because of the most
    // negative sample.
    // ------------------------------------------------------------------
    function automatic logic [16:0] magnitude(input logic signed [15:0] x);
        logic signed [16:0] wide;
        wide = {x[15], x};
        return x[15] ? 17'(-wide) : 17'(wide);
    endfunction

    logic [16:0] mag_a, mag_b, mag_c;
    logic [19:0] near_thresh;
    logic        cur_near;
    logic        cur_over;
    logic [3:0]  near_inc;

    assign mag_a       = magnitude(item_reg.phase_a);
    assign mag_b       = magnitude(item_reg.phase_b);
    assign mag_c       = magnitude(item_reg.phase_c);
    assign near_thresh = 20'(current_limit_reg) * 20'd9;
    assign cur_near    = (20'(mag_a) * 20'd10 > near_thresh)
                      || (20'(mag_b) * 20'd10 > near_thresh)
                      || (20'(mag_c) * 20'd10 > near_thresh);
    assign cur_over    = (mag_a > 17'(current_limit_reg))
                      || (mag_b > 17'(current_limit_reg))
                      || (mag_c > 17'(current_limit_reg));
    assign near_inc    = near_cnt_reg + 4'd1;

    // ------------------------------------------------------------------
    // Bus checks. The under-voltage test is written as v + T < N so that
    // it never fires when the tolerance exceeds the nominal value.
    // ------------------------------------------------------------------
    logic        bus_over;
    logic        bus_under;
    logic [12:0] brake_excess;
    logic [14:0] brake_excess_x4;
    logic [30:0] fifth_prod;
    logic [12:0] duty_cut;
    logic [10:0] duty_calc;

    assign bus_over  = 15'(item_reg.bus_voltage)
                     > 15'(bus_nominal_reg) + 15'(bus_tolerance_reg);
    assign bus_under = 15'(item_reg.bus_voltage) + 15'(bus_tolerance_reg)
                     < 15'(bus_nominal_reg);

    // Duty falls by 4/5 of a count per 1/16 V above the brake start level;
    // the divide by five is a multiply by a scaled reciprocal.
    assign brake_excess    = 13'(item_reg.bus_voltage - BRAKE_START);
    assign brake_excess_x4 = {brake_excess, 2'b00};
    assign fifth_prod      = 31'(brake_excess_x4) * 31'(RECIP_FIFTH);
    assign duty_cut        = fifth_prod[30:18];

    always_comb
    begin
        if (item_reg.bus_voltage < BRAKE_START)
        begin
            duty_calc = DUTY_FULL;
        end
        else if (duty_cut > DUTY_CUT_MAX)
        begin
            duty_calc = DUTY_MIN;
        end
        else
        begin
            duty_calc = DUTY_FULL - duty_cut[10:0];
        end
    end

    // ------------------------------------------------------------------
    // Temperature checks: fan on above 3/8 of the limit, off below 27/80,
    // the off test taking priority.
    // ------------------------------------------------------------------
    logic signed [19:0] temp_ext;
    logic signed [19:0] limit_ext;
    logic               fan_set;
    logic               fan_clr;
    logic               temp_over;

    assign temp_ext  = 20'(item_reg.temperature);
    assign limit_ext = $signed({9'd0, temp_limit_reg});
    assign fan_set   = (temp_ext <<< 3) > limit_ext * 20'sd3;
    assign fan_clr   = temp_ext * 20'sd80 < limit_ext * 20'sd27;
    assign temp_over = temp_ext > limit_ext;

    // ------------------------------------------------------------------
    // Next-state logic for the transaction in the input register
    // ------------------------------------------------------------------
    logic gate_stop;

    assign gate_stop = stop_reg || (fault_reg != 5'd0);

    always_comb
    begin
        stop_next     = stop_reg;
        brake_next    = brake_reg;
        fault_next    = fault_reg;
        near_cnt_next = near_cnt_reg;
        fan_next      = fan_reg;
        duty_next     = duty_reg;
        case (item_reg.cmd)
            CMD_CURRENT:
            begin
                if (cur_near)
                begin
                    if (near_inc > NEAR_TRIP)
                    begin
                        near_cnt_next               = 4'd0;
                        stop_next                   = 1'b1;
                        fault_next[FLT_OVERCURRENT] = 1'b1;
                    end
                    else
                    begin
                        near_cnt_next = near_inc;
                    end
                end
                if (cur_over)
                begin
                    stop_next                   = 1'b1;
                    fault_next[FLT_MAX_CURRENT] = 1'b1;
                end
            end
            CMD_BUS:
            begin
                if (bus_over)
                begin
                    stop_next                 = 1'b1;
                    fault_next[FLT_OVERVOLT]  = 1'b1;
                end
                if (bus_under)
                begin
                    stop_next                 = 1'b1;
                    fault_next[FLT_UNDERVOLT] = 1'b1;
                end
                duty_next = duty_calc;
            end
            CMD_TEMP:
            begin
                if (fan_set)
                begin
                    fan_next = 1'b1;
                end
                if (fan_clr)
                begin
                    fan_next = 1'b0;
                end
                if (temp_over)
                begin
                    stop_next                = 1'b1;
                    fault_next[FLT_OVERHEAT] = 1'b1;
                end
            end
            CMD_GATE:
            begin
                // A stopped or faulted drive asserts the brake; a running drive with
                // the enable pin low stops but leaves the brake for the
                // next gate evaluation.
                if (gate_stop)
                begin
                    stop_next  = 1'b1;
                    brake_next = 1'b1;
                end
                else if (item_reg.enable_pin)
                begin
                    stop_next  = 1'b0;
                    brake_next = 1'b0;
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end
            CMD_STOP:
            begin
                stop_next = item_reg.stop_value;
            end
            CMD_CLEAR:
            begin
                fault_next = 5'd0;
            end
            default:
            begin
                // Unused command codes only report the current state.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg     <= 1'b1;
            brake_reg    <= 1'b0;
            fault_reg    <= 5'd0;
            near_cnt_reg <= 4'd0;
            fan_reg      <= 1'b0;
            duty_reg     <= DUTY_FULL;
        end
        else if (advance)
        begin
            stop_reg     <= stop_next;
            brake_reg    <= brake_next;
            fault_reg    <= fault_next;
            near_cnt_reg <= near_cnt_next;
            fan_reg      <= fan_next;
            duty_reg     <= duty_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: a snapshot of the state after each transaction,
    // held until the downstream side takes it.
    // ------------------------------------------------------------------
    logic        res_stop_reg;
    logic        res_brake_reg;
    logic [4:0]  res_fault_reg;
    logic        res_fan_reg;
    logic [10:0] res_duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_stop_reg  <= stop_next;
            res_brake_reg <= brake_next;
            res_fault_reg <= fault_next;
            res_fan_reg   <= fan_next;
            res_duty_reg  <= duty_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign stop         = res_stop_reg;
    assign brake_active = res_brake_reg;
    assign fault_flags  = res_fault_reg;
    assign fan_on       = res_fan_reg;
    assign brake_duty   = res_duty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The near-limit counter wraps to zero on trip and never rests above it.
    assert property (@(posedge clk) disable iff (!rst_n)
        near_cnt_reg <= NEAR_TRIP)
    else $error("near-limit counter above trip value");

    // The brake duty always stays inside its clamp window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (brake_duty >= DUTY_MIN) && (brake_duty <= DUTY_FULL))
    else $error("brake duty outside clamp window");

    // A clear-faults transaction leaves no fault flag behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.cmd == CMD_CLEAR) |=> (fault_reg == 5'd0))
    else $error("fault flags not cleared");

    // Gate evaluation with a latched fault always stops and brakes.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.cmd == CMD_GATE) && (fault_reg != 5'd0)
        |=> stop_reg && brake_reg)
    else $error("gate evaluation with fault did not stop and brake");

    // A result appears only in the cycle after a transaction left the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
    else $error("result without a processed transaction");

endmodule
